// File: design/hasp_pkg.sv
// Shared types and constants for the highest-averages seat picker.
package hasp_pkg;

  // Fixed field widths
  localparam int REQ_W      = 2;
  localparam int IDX_W      = 11;
  localparam int VAL_W      = 30;
  localparam int CNT_W      = 11;
  localparam int WIN_W      = 8;
  localparam int STAT_W     = 2;
  localparam int NE_IN_W    = 9;
  localparam int CFG_W      = 11;
  localparam int CFG_ADDR_W = 1;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 16;

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_NUM_ENTRIES   = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_DIVISOR_COUNT = 1'b1;

  // Result status codes
  localparam logic [STAT_W-1:0] RES_OK        = 2'd0;
  localparam logic [STAT_W-1:0] RES_RANGE     = 2'd1;
  localparam logic [STAT_W-1:0] RES_EXHAUSTED = 2'd2;

  typedef enum logic [REQ_W-1:0] {
    REQ_WEIGHT  = 2'd0,
    REQ_DIVISOR = 2'd1,
    REQ_PICK    = 2'd2,
    REQ_RESTART = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_DRAIN,
    S_COMMIT,
    S_WIPE,
    S_DONE
  } state_t;

  typedef struct packed {
    logic in_load;
    logic decode;
    logic wr_weight;
    logic wr_div;
    logic cnt_clr;
    logic cnt_inc;
    logic clear_wr;
    logic scan_start;
    logic issue;
    logic commit;
    logic picks_clr;
    logic out_load;
  } hasp_cmd_t;

  typedef struct packed {
    req_t req;
    logic exhausted;
    logic cnt_last_all;
    logic cnt_last_used;
    logic pipe_empty;
    logic out_busy;
  } hasp_sts_t;

endpackage

// File: design/hasp_ctrl.sv
// Sequencer for the seat picker: input handshake, scan and sweep control.
module hasp_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  hasp_pkg::hasp_sts_t  sts,
  output hasp_pkg::hasp_cmd_t  cmd
);
  import hasp_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_INIT: begin
        if (sts.cnt_last_all) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (s_tvalid) state_next = S_DECODE;
      end
      S_DECODE: begin
        unique case (sts.req)
          REQ_WEIGHT, REQ_DIVISOR: state_next = S_DONE;
          REQ_PICK:                state_next = sts.exhausted ? S_DONE : S_SCAN;
          REQ_RESTART:             state_next = S_WIPE;
          default:                 state_next = S_DONE;
        endcase
      end
      S_SCAN: begin
        if (sts.cnt_last_used) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        if (sts.pipe_empty) state_next = S_COMMIT;
      end
      S_COMMIT: begin
        state_next = S_DONE;
      end
      S_WIPE: begin
        if (sts.cnt_last_all) state_next = S_DONE;
      end
      S_DONE: begin
        if (!sts.out_busy) state_next = S_IDLE;
      end
      default: state_next = S_INIT;
    endcase
  end

  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    unique case (state)
      S_INIT: begin
        cmd.clear_wr = 1'b1;
        cmd.cnt_inc  = 1'b1;
      end
      S_IDLE: begin
        s_tready    = 1'b1;
        cmd.in_load = s_tvalid;
      end
      S_DECODE: begin
        cmd.decode     = 1'b1;
        cmd.cnt_clr    = 1'b1;
        cmd.wr_weight  = (sts.req == REQ_WEIGHT);
        cmd.wr_div     = (sts.req == REQ_DIVISOR);
        cmd.scan_start = (sts.req == REQ_PICK) && !sts.exhausted;
        cmd.picks_clr  = (sts.req == REQ_RESTART);
      end
      S_SCAN: begin
        cmd.issue   = 1'b1;
        cmd.cnt_inc = 1'b1;
      end
      S_DRAIN: begin
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
      end
      S_WIPE: begin
        cmd.clear_wr = 1'b1;
        cmd.cnt_inc  = 1'b1;
      end
      S_DONE: begin
        cmd.out_load = !sts.out_busy;
      end
      default: begin
      end
    endcase
  end

  a_scan_ends_in_drain: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && sts.cnt_last_used) |=> (state == S_DRAIN))
    else $error("scan did not stop after the last entry");

  a_decode_after_accept: assert property (@(posedge clk) disable iff (rst)
    (state == S_DECODE) |-> ($past(state) == S_IDLE && $past(s_tvalid)))
    else $error("decode entered without an accepted beat");

endmodule

// File: design/hasp_datapath.sv
// Datapath of the seat picker: stores, scan pipeline, best tracker, result register.
module hasp_datapath #(
  parameter int MAX_ENTRIES = 256,
  parameter int MAX_ROUNDS  = 1024
) (
  input  logic                               clk,
  input  logic                               rst,
  input  hasp_pkg::hasp_cmd_t                cmd,
  output hasp_pkg::hasp_sts_t                sts,
  input  logic                               cfg_wr_en,
  input  logic [hasp_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [hasp_pkg::CFG_W-1:0]         cfg_wdata,
  input  logic [hasp_pkg::IN_DATA_W-1:0]     s_tdata,
  input  logic [hasp_pkg::REQ_W-1:0]         s_tuser,
  input  logic                               m_tready,
  output logic                               m_tvalid,
  output logic [hasp_pkg::OUT_DATA_W-1:0]    m_tdata
);
  import hasp_pkg::*;

  localparam int EW     = $clog2(MAX_ENTRIES);
  localparam int RW     = (MAX_ROUNDS > 1) ? $clog2(MAX_ROUNDS) : 1;
  localparam int NW     = $clog2(MAX_ENTRIES + 1);
  localparam int DW     = $clog2(MAX_ROUNDS + 1);
  localparam int PW     = 2 * VAL_W;
  localparam int PAD_W  = OUT_DATA_W - WIN_W - STAT_W;

  // Configuration registers, saturated on write
  logic [NW-1:0]      num_entries;
  logic [DW-1:0]      divisor_count;
  logic [NE_IN_W-1:0] ne_raw;
  logic [NW-1:0]      ne_clamp;
  logic [DW-1:0]      dc_clamp;

  assign ne_raw = cfg_wdata[NE_IN_W-1:0];

  always_comb begin
    if (ne_raw == '0) begin
      ne_clamp = NW'(1);
    end else if (32'(ne_raw) > MAX_ENTRIES) begin
      ne_clamp = NW'(MAX_ENTRIES);
    end else begin
      ne_clamp = NW'(ne_raw);
    end
    if (cfg_wdata == '0) begin
      dc_clamp = DW'(1);
    end else if (32'(cfg_wdata) > MAX_ROUNDS) begin
      dc_clamp = DW'(MAX_ROUNDS);
    end else begin
      dc_clamp = DW'(cfg_wdata);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_entries   <= NW'(1);
      divisor_count <= DW'(1);
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        CFG_NUM_ENTRIES:   num_entries   <= ne_clamp;
        CFG_DIVISOR_COUNT: divisor_count <= dc_clamp;
        default: begin
        end
      endcase
    end
  end

  // Held input beat
  req_t             req_q;
  logic [IDX_W-1:0] idx_q;
  logic [VAL_W-1:0] val_q;

  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      req_q <= req_t'(s_tuser);
      idx_q <= s_tdata[IDX_W-1:0];
      val_q <= s_tdata[IDX_W+VAL_W-1:IDX_W];
    end
  end

  logic [31:0]      idx32;
  logic [31:0]      seat32;
  logic             w_in_range;
  logic             d_in_range;
  logic [EW-1:0]    w_waddr;
  logic [RW-1:0]    d_waddr;
  logic [VAL_W-1:0] div_val;

  assign idx32      = 32'(idx_q);
  assign seat32     = idx32 - 32'd1;
  assign w_in_range = idx32 < MAX_ENTRIES;
  assign d_in_range = (idx_q != '0) && (idx32 <= MAX_ROUNDS);
  assign w_waddr    = idx32[EW-1:0];
  assign d_waddr    = seat32[RW-1:0];
  assign div_val    = (val_q == '0) ? VAL_W'(1) : val_q;

  // Shared address counter for scans and clearing sweeps
  logic [EW-1:0] cnt;
  logic [NW-1:0] ne_dec;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.cnt_clr) begin
      cnt <= '0;
    end else if (cmd.cnt_inc) begin
      cnt <= cnt + 1'b1;
    end
  end

  assign ne_dec = num_entries - NW'(1);

  // Best candidate so far
  logic             have;
  logic             last_won;
  logic [EW-1:0]    best;
  logic [VAL_W-1:0] bw;
  logic [VAL_W-1:0] bd;
  logic [CNT_W-1:0] bc;
  logic [31:0]      best32;

  assign best32 = 32'(best);

  // Memories
  logic [VAL_W-1:0] wmem [MAX_ENTRIES];
  logic [CNT_W-1:0] cmem [MAX_ENTRIES];
  logic [VAL_W-1:0] dmem [MAX_ROUNDS];
  logic [VAL_W-1:0] w_rd;
  logic [CNT_W-1:0] c_rd;
  logic [VAL_W-1:0] d_rd;
  logic             c_we;
  logic [EW-1:0]    c_waddr;
  logic [CNT_W-1:0] c_wdata;
  logic [31:0]      c_rd32;
  logic [RW-1:0]    d_raddr;

  assign c_we    = cmd.clear_wr || (cmd.commit && have);
  assign c_waddr = cmd.clear_wr ? cnt : best;
  assign c_wdata = cmd.clear_wr ? '0 : bc + 1'b1;
  assign c_rd32  = 32'(c_rd);
  assign d_raddr = c_rd32[RW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.wr_weight && w_in_range) wmem[w_waddr] <= val_q;
    w_rd <= wmem[cnt];
  end

  always_ff @(posedge clk) begin
    if (c_we) cmem[c_waddr] <= c_wdata;
    c_rd <= cmem[cnt];
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_div && d_in_range) dmem[d_waddr] <= div_val;
    d_rd <= dmem[d_raddr];
  end

  // Scan pipeline: issue, count read, divisor read, products, compare
  logic             v1, v2, v3;
  logic [EW-1:0]    i1, i2, i3;
  logic [VAL_W-1:0] w2, w3, d3;
  logic [CNT_W-1:0] c2, c3;
  logic             ok2, ok3;
  logic [PW-1:0]    pa_n, pb_n, pc_n, pd_n;
  logic [PW-1:0]    pa, pb, pc, pd;
  logic [PW-1:0]    lhs, rhs;
  logic             win;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= cmd.issue;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // Products against the registered best and against the candidate one stage ahead
  assign pa_n = w2 * bd;
  assign pb_n = bw * d_rd;
  assign pc_n = w2 * d3;
  assign pd_n = w3 * d_rd;

  always_ff @(posedge clk) begin
    i1  <= cnt;
    i2  <= i1;
    w2  <= w_rd;
    c2  <= c_rd;
    ok2 <= c_rd32 < MAX_ROUNDS;
    i3  <= i2;
    w3  <= w2;
    d3  <= d_rd;
    c3  <= c2;
    ok3 <= ok2;
    pa  <= pa_n;
    pb  <= pb_n;
    pc  <= pc_n;
    pd  <= pd_n;
  end

  // If the previous candidate just took the lead, compare against it instead
  assign lhs = last_won ? pc : pa;
  assign rhs = last_won ? pd : pb;
  assign win = v3 && ok3 && (!have || (lhs > rhs));

  always_ff @(posedge clk) begin
    if (rst) begin
      have     <= 1'b0;
      last_won <= 1'b0;
    end else if (cmd.scan_start) begin
      have     <= 1'b0;
      last_won <= 1'b0;
    end else begin
      last_won <= win;
      if (win) have <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (win) begin
      best <= i3;
      bw   <= w3;
      bd   <= d3;
      bc   <= c3;
    end
  end

  // Pick tally
  logic [CNT_W-1:0] picks_done;

  always_ff @(posedge clk) begin
    if (rst || cmd.picks_clr) begin
      picks_done <= '0;
    end else if (cmd.commit) begin
      picks_done <= picks_done + 1'b1;
    end
  end

  // Result and output register
  logic [WIN_W-1:0]  res_winner;
  logic [STAT_W-1:0] res_status;
  logic [STAT_W-1:0] status_n;

  always_comb begin
    status_n = RES_OK;
    unique case (req_q)
      REQ_WEIGHT:  status_n = w_in_range ? RES_OK : RES_RANGE;
      REQ_DIVISOR: status_n = d_in_range ? RES_OK : RES_RANGE;
      REQ_PICK:    status_n = sts.exhausted ? RES_EXHAUSTED : RES_OK;
      REQ_RESTART: status_n = RES_OK;
      default:     status_n = RES_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.decode) begin
      res_winner <= '0;
      res_status <= status_n;
    end else if (cmd.commit && have) begin
      res_winner <= best32[WIN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) m_tdata <= {PAD_W'(0), res_status, res_winner};
  end

  assign sts.req           = req_q;
  assign sts.exhausted     = 32'(picks_done) >= 32'(divisor_count);
  assign sts.cnt_last_all  = 32'(cnt) == (MAX_ENTRIES - 1);
  assign sts.cnt_last_used = 32'(cnt) == 32'(ne_dec);
  assign sts.pipe_empty    = !v1 && !v2 && !v3;
  assign sts.out_busy      = m_tvalid && !m_tready;

  a_commit_after_drain: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!v1 && !v2 && !v3))
    else $error("seat committed while candidates still in flight");

  a_lead_moves_up: assert property (@(posedge clk) disable iff (rst)
    (win && have) |-> (i3 > best))
    else $error("lead taken by an entry that is not above the current best");

  a_last_won_has_best: assert property (@(posedge clk) disable iff (rst)
    last_won |-> have)
    else $error("forwarding flag set without a best candidate");

endmodule

// File: design/highest_averages_seat_picker.sv
// Highest-averages seat picker: one result beat for every accepted request beat.
// A weight or divisor write goes from accept through the decode and done states to the
// output register. A pick that is not exhausted scans entries 0..num_entries-1 through
// the count, divisor and weight memories at one entry per cycle, then drains the scan
// pipeline and commits the seat. A restart clears the seat counts with one write per
// cycle. After reset a clearing pass over all MAX_ENTRIES seat counts runs before the
// first request beat is taken; configuration writes are taken at any time. A finished
// result waits in an output register, and the next request beat is accepted while it
// waits.
module highest_averages_seat_picker #(
  parameter int MAX_ENTRIES = 256,
  parameter int MAX_ROUNDS  = 1024
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [hasp_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [hasp_pkg::CFG_W-1:0]       cfg_wdata,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [hasp_pkg::IN_DATA_W-1:0]   s_tdata,   // index[10:0], value[40:11], zero pad
  input  logic [hasp_pkg::REQ_W-1:0]       s_tuser,   // req_type[1:0]
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [hasp_pkg::OUT_DATA_W-1:0]  m_tdata    // winner[7:0], status[9:8], zero pad
);
  import hasp_pkg::*;

  hasp_cmd_t cmd;
  hasp_sts_t sts;

  hasp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  hasp_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .MAX_ROUNDS  (MAX_ROUNDS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tready  (m_tready),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata)
  );

endmodule

// File: verif/tb_highest_averages_seat_picker.sv
// Self-checking testbench for the highest-averages seat picker: scoreboard, drivers, stimulus.
module tb_highest_averages_seat_picker;
  import hasp_pkg::*;

  localparam int MAX_ENTRIES  = 256;
  localparam int MAX_ROUNDS   = 1024;
  localparam int RANDOM_BEATS = 750;
  localparam int DIV_PRELOAD  = 80;
  localparam int PICK_BOUND   = 40;
  localparam int LONG_HOLD    = 400;
  localparam int IDLE_LIMIT   = 4000;
  localparam int END_SETTLE   = 300;
  localparam int PAD_W        = IN_DATA_W - IDX_W - VAL_W;
  localparam logic [VAL_W-1:0] VAL_MAX = '1;

  typedef struct packed {
    logic [WIN_W-1:0]  winner;
    logic [STAT_W-1:0] status;
  } award_t;

  typedef enum int {SHAPE_DHONDT, SHAPE_ODD, SHAPE_RANDOM, SHAPE_FLAT, SHAPE_ZERO} div_shape_t;
  typedef enum int {FLOW_OPEN, FLOW_CHOPPY, FLOW_STARVED} flow_t;

  class seat_scoreboard;
    logic [VAL_W-1:0]   weights [MAX_ENTRIES];
    logic [VAL_W-1:0]   divisors [MAX_ROUNDS];
    logic [CNT_W-1:0]   seats [MAX_ENTRIES];
    logic [CNT_W-1:0]   picks_taken;
    logic [NE_IN_W-1:0] entries_used;
    logic [CFG_W-1:0]   rounds_allowed;
    award_t awards_due[$];
    int mismatches, results_checked;
    int seats_awarded, picks_refused, range_rejects, restarts;

    function new();
      foreach (weights[i]) weights[i] = '0;
      foreach (divisors[i]) divisors[i] = '0;
      foreach (seats[i]) seats[i] = '0;
      picks_taken = '0;
      entries_used = 1;
      rounds_allowed = 1;
    endfunction

    // Saturate into the legal range as the block does on a write.
    function void apply_register(logic [CFG_ADDR_W-1:0] addr, logic [CFG_W-1:0] data);
      if (addr == CFG_NUM_ENTRIES)
        entries_used = (data[NE_IN_W-1:0] == 0) ? NE_IN_W'(1) :
                       (data[NE_IN_W-1:0] > MAX_ENTRIES) ? NE_IN_W'(MAX_ENTRIES) :
                       data[NE_IN_W-1:0];
      else
        rounds_allowed = (data == 0) ? CFG_W'(1) :
                         (data > MAX_ROUNDS) ? CFG_W'(MAX_ROUNDS) : data;
    endfunction

    function void note_request(req_t r, logic [IDX_W-1:0] idx, logic [VAL_W-1:0] val);
      award_t due;
      logic found;
      int best, seat;
      logic [63:0] best_w, best_d, w, d;
      due.winner = '0;
      due.status = RES_OK;
      found = 1'b0;
      best = 0;
      best_w = '0;
      best_d = '0;
      case (r)
        REQ_WEIGHT: begin
          if (idx < MAX_ENTRIES) weights[idx] = val;
          else due.status = RES_RANGE;
        end
        REQ_DIVISOR: begin
          if (idx >= 1 && idx <= MAX_ROUNDS) divisors[idx - 1] = (val == 0) ? VAL_W'(1) : val;
          else due.status = RES_RANGE;
        end
        REQ_PICK: begin
          if (picks_taken >= rounds_allowed) begin
            due.status = RES_EXHAUSTED;
          end else begin
            // Compare quotients exactly through cross products; ties keep the lower index.
            for (int e = 0; e < entries_used; e++) begin
              seat = int'(seats[e]) + 1;
              if (seat > MAX_ROUNDS) continue;
              w = 64'(weights[e]);
              d = 64'(divisors[seat - 1]);
              if (!found || w * best_d > best_w * d) begin
                found = 1'b1;
                best = e;
                best_w = w;
                best_d = d;
              end
            end
            if (found) begin
              seats[best] = seats[best] + 1'b1;
              due.winner = best[WIN_W-1:0];
            end
            picks_taken = picks_taken + 1'b1;
          end
        end
        default: begin
          foreach (seats[i]) seats[i] = '0;
          picks_taken = '0;
          restarts++;
        end
      endcase
      if (r == REQ_PICK && due.status == RES_OK) seats_awarded++;
      if (due.status == RES_EXHAUSTED) picks_refused++;
      if (due.status == RES_RANGE) range_rejects++;
      awards_due.push_back(due);
    endfunction

    function void check_result(logic [WIN_W-1:0] winner, logic [STAT_W-1:0] status);
      award_t due;
      results_checked++;
      if (awards_due.size() == 0) begin
        $error("result beat with nothing pending: winner %0d status %0d", winner, status);
        mismatches++;
        return;
      end
      due = awards_due.pop_front();
      if (winner !== due.winner) begin
        $error("winner mismatch: expected %0d, actual %0d", due.winner, winner);
        mismatches++;
      end
      if (status !== due.status) begin
        $error("status mismatch: expected %0d, actual %0d", due.status, status);
        mismatches++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  cfg_wr_en;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_W-1:0]      cfg_wdata;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic [REQ_W-1:0]      s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;

  seat_scoreboard sb;
  int beats_sent;
  int burst_left;
  int hold_asks;
  int reg_writes;

  highest_averages_seat_picker #(
    .MAX_ENTRIES(MAX_ENTRIES),
    .MAX_ROUNDS (MAX_ROUNDS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready)
      sb.note_request(req_t'(s_tuser), s_tdata[IDX_W-1:0], s_tdata[IDX_W +: VAL_W]);
    if (!rst && m_tvalid && m_tready)
      sb.check_result(m_tdata[WIN_W-1:0], m_tdata[WIN_W +: STAT_W]);
  end

  // Receiver: its own stall pattern, plus long hold-offs on request.
  initial begin
    int hold_left, run_left, holds_done;
    flow_t flow;
    hold_left = 0;
    run_left = 0;
    holds_done = 0;
    flow = FLOW_OPEN;
    m_tready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left == 0 && holds_done < hold_asks) begin
        holds_done++;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        if (run_left == 0) begin
          flow = flow_t'($urandom_range(0, 2));
          run_left = $urandom_range(8, 60);
        end
        run_left--;
        case (flow)
          FLOW_OPEN:   m_tready <= 1'b1;
          FLOW_CHOPPY: m_tready <= ($urandom_range(0, 1) == 0);
          default:     m_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    int idle_cycles;
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d results pending",
               idle_cycles, sb.awards_due.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic load_register(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= data;
    @(posedge clk);
    sb.apply_register(addr, data);
    reg_writes++;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Offer one request beat; bursts of random length with random gaps between them.
  task automatic send_beat(input req_t req, input logic [IDX_W-1:0] idx,
                           input logic [VAL_W-1:0] val);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        @(negedge clk);
        s_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser <= req;
    s_tdata <= {{PAD_W{1'b0}}, val, idx};
    do @(posedge clk); while (!s_tready);
    beats_sent++;
  endtask

  // Hold the sender until every pending result has come back.
  task automatic wait_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sb.awards_due.size() != 0) @(posedge clk);
  endtask

  function automatic logic [VAL_W-1:0] rand_weight();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return '0;
    if (roll == 1) return VAL_MAX;
    if (roll < 5) return VAL_W'($urandom_range(0, 100));
    return VAL_W'($urandom);
  endfunction

  function automatic logic [VAL_W-1:0] divisor_for(div_shape_t shape, int seat);
    case (shape)
      SHAPE_DHONDT: return VAL_W'(seat);
      SHAPE_ODD:    return VAL_W'(2 * seat - 1);
      SHAPE_RANDOM: return VAL_W'($urandom);
      SHAPE_FLAT:   return VAL_MAX;
      default:      return '0;
    endcase
  endfunction

  // Broken sequences and rejects mixed into a round.
  task automatic send_noise(input int ne);
    case ($urandom_range(0, 4))
      0: send_beat(REQ_WEIGHT, IDX_W'($urandom_range(MAX_ENTRIES, 2047)), rand_weight());
      1: send_beat(REQ_DIVISOR, '0, VAL_W'($urandom));
      2: send_beat(REQ_DIVISOR, IDX_W'($urandom_range(MAX_ROUNDS + 1, 2047)), VAL_W'($urandom));
      3: send_beat(REQ_WEIGHT, IDX_W'($urandom_range(0, ne - 1)), rand_weight());
      default: send_beat(REQ_RESTART, IDX_W'($urandom), VAL_W'($urandom));
    endcase
  endtask

  // Fill every weight and the divisors of every seat a round can reach, so no pick
  // ever reads an unwritten entry.
  task automatic preload();
    for (int e = 0; e < MAX_ENTRIES; e++) send_beat(REQ_WEIGHT, IDX_W'(e), rand_weight());
    for (int s = 1; s <= DIV_PRELOAD; s++)
      send_beat(REQ_DIVISOR, IDX_W'(s), divisor_for(SHAPE_DHONDT, s));
  endtask

  task automatic directed();
    wait_drained();
    load_register(CFG_NUM_ENTRIES, CFG_W'(4));
    load_register(CFG_DIVISOR_COUNT, CFG_W'(6));
    send_beat(REQ_RESTART, '0, '0);
    send_beat(REQ_WEIGHT, IDX_W'(0), VAL_MAX);
    send_beat(REQ_WEIGHT, IDX_W'(1), VAL_MAX);
    send_beat(REQ_WEIGHT, IDX_W'(2), '0);
    send_beat(REQ_WEIGHT, IDX_W'(3), VAL_W'(1));
    send_beat(REQ_WEIGHT, IDX_W'(MAX_ENTRIES), VAL_MAX);
    send_beat(REQ_WEIGHT, '1, '0);
    send_beat(REQ_DIVISOR, '0, VAL_W'(5));
    send_beat(REQ_DIVISOR, IDX_W'(MAX_ROUNDS + 1), VAL_W'(5));
    send_beat(REQ_DIVISOR, '1, VAL_MAX);
    send_beat(REQ_DIVISOR, IDX_W'(1), '0);
    send_beat(REQ_DIVISOR, IDX_W'(2), VAL_MAX);
    send_beat(REQ_DIVISOR, IDX_W'(3), VAL_W'(3));
    send_beat(REQ_DIVISOR, IDX_W'(MAX_ROUNDS), VAL_MAX);
    repeat (6) send_beat(REQ_PICK, '0, '0);
    send_beat(REQ_PICK, '1, VAL_MAX);
    send_beat(REQ_RESTART, '1, VAL_MAX);
    send_beat(REQ_PICK, '0, '0);
  endtask

  // One round: settings, optional restart, reloads, then picks up to and past a small limit.
  task automatic run_phase(input int n);
    logic [CFG_W-1:0] ne_raw, dc_raw;
    int ne, dc, picks, seats_loaded;
    div_shape_t shape;
    wait_drained();
    case (n)
      0: begin ne_raw = '0; dc_raw = '1; end
      1: begin ne_raw = CFG_W'(511); dc_raw = '0; end
      2: begin ne_raw = CFG_W'(MAX_ENTRIES); dc_raw = CFG_W'(MAX_ROUNDS); end
      3: begin ne_raw = CFG_W'(11'h605); dc_raw = CFG_W'(12); end
      default: begin
        ne_raw = ($urandom_range(0, 9) == 0) ? CFG_W'($urandom) : CFG_W'($urandom_range(1, 12));
        dc_raw = ($urandom_range(0, 9) == 0) ? CFG_W'($urandom) : CFG_W'($urandom_range(1, 24));
      end
    endcase
    load_register(CFG_NUM_ENTRIES, ne_raw);
    load_register(CFG_DIVISOR_COUNT, dc_raw);
    ne = int'(sb.entries_used);
    dc = int'(sb.rounds_allowed);
    // Starve the output while requests keep coming, so the input backs up.
    if (n == 3 || $urandom_range(0, 14) == 0) hold_asks++;
    // Restart often, and always once the tally grows, so seats stay in the loaded divisors.
    if (n < 4 || $urandom_range(0, 4) != 0 || int'(sb.picks_taken) > PICK_BOUND)
      send_beat(REQ_RESTART, IDX_W'($urandom), VAL_W'($urandom));
    repeat ($urandom_range(0, 4))
      send_beat(REQ_WEIGHT, IDX_W'($urandom_range(0, ne - 1)), rand_weight());
    shape = div_shape_t'($urandom_range(0, 4));
    seats_loaded = $urandom_range(0, 8);
    if (seats_loaded > dc) seats_loaded = dc;
    for (int s = 1; s <= seats_loaded; s++)
      send_beat(REQ_DIVISOR, IDX_W'(s), divisor_for(shape, s));
    picks = (ne <= 16) ? ((dc < 30) ? dc : 30) + $urandom_range(0, 2) : $urandom_range(1, 3);
    repeat (picks) begin
      if ($urandom_range(0, 9) == 0) send_noise(ne);
      send_beat(REQ_PICK, IDX_W'($urandom), VAL_W'($urandom));
    end
  endtask

  initial begin
    int phase_no, random_start;
    sb = new();
    beats_sent = 0;
    burst_left = 0;
    hold_asks = 0;
    reg_writes = 0;
    rst <= 1'b1;
    cfg_wr_en <= 1'b0;
    cfg_addr <= '0;
    cfg_wdata <= '0;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tuser <= '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    preload();
    directed();
    random_start = beats_sent;
    phase_no = 0;
    while (beats_sent - random_start < RANDOM_BEATS) begin
      run_phase(phase_no);
      phase_no++;
    end
    wait_drained();
    repeat (END_SETTLE) @(posedge clk);

    if (sb.awards_due.size() != 0) begin
      $error("%0d expected results never arrived", sb.awards_due.size());
      sb.mismatches++;
    end
    $display("Run covered %0d request beats in %0d rounds and %0d register writes.",
             beats_sent, phase_no, reg_writes);
    $display("Seats awarded %0d, picks refused %0d, range rejects %0d, restarts %0d, checked %0d.",
             sb.seats_awarded, sb.picks_refused, sb.range_rejects, sb.restarts,
             sb.results_checked);
    if (sb.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: sim.f
design/hasp_pkg.sv
design/hasp_ctrl.sv
design/hasp_datapath.sv
design/highest_averages_seat_picker.sv
verif/tb_highest_averages_seat_picker.sv
